[sv/csfp_pkg.sv]
// ---------------------------------------------------------------------------
// csfp_pkg
// shared constants, codes and field offset tables of the charger status
// frame parser
// ---------------------------------------------------------------------------
`default_nettype none

package csfp_pkg;

  localparam logic [7:0]  SYNC_BYTE      = 8'hAA;
  localparam logic [7:0]  RESP_CODE      = 8'h03;
  localparam logic [7:0]  ITEM_STATUS    = 8'h00;
  localparam logic [7:0]  ITEM_LOG       = 8'h02;
  localparam logic [8:0]  STATUS_MIN_LEN = 9'd35;
  localparam logic [8:0]  LOG_MIN_LEN    = 9'd53;
  localparam logic [8:0]  STORE_DEPTH    = 9'd52;
  localparam logic [8:0]  HDR_LEN        = 9'd7;
  localparam logic [8:0]  PAY_POS        = 9'd6;
  localparam logic [8:0]  CODE_POS       = 9'd3;
  localparam logic [8:0]  ITEM_POS       = 9'd4;
  localparam logic [8:0]  CNT_MAX        = 9'd511;
  localparam logic [15:0] IDLE_MAX       = 16'hFFFF;
  localparam logic [15:0] TIMEOUT_RST    = 16'd500;
  localparam logic [3:0]  STAT_LAST      = 4'd10;
  localparam logic [3:0]  LOG_LAST       = 4'd5;

  localparam int MEM_DEPTH = 32;
  localparam int MEM_AW    = $clog2(MEM_DEPTH);

  typedef enum logic [2:0] {
    FS_STAT_FIELD = 3'd0,
    FS_LOG_FIELD  = 3'd1,
    FS_BAD_CODE   = 3'd2,
    FS_CHECKSUM   = 3'd3,
    FS_UNKNOWN    = 3'd4,
    FS_SHORT      = 3'd5,
    FS_TIMEOUT    = 3'd6
  } fstat_t;

  typedef enum logic [2:0] {
    JOB_ERR  = 3'b001,
    JOB_STAT = 3'b010,
    JOB_LOG  = 3'b100
  } job_kind_t;

  // byte offset of a 16-bit status field
  function automatic logic [5:0] stat_off(input logic [3:0] idx);
    logic [5:0] off;
    case (idx)
      4'd0:    off = 6'd8;
      4'd1:    off = 6'd10;
      4'd2:    off = 6'd12;
      4'd3:    off = 6'd14;
      4'd4:    off = 6'd18;
      4'd5:    off = 6'd20;
      4'd6:    off = 6'd22;
      4'd7:    off = 6'd24;
      4'd8:    off = 6'd26;
      4'd9:    off = 6'd28;
      4'd10:   off = 6'd30;
      default: off = 6'd8;
    endcase
    return off;
  endfunction

  // byte offset of a 32-bit log field
  function automatic logic [5:0] log_off(input logic [3:0] idx);
    logic [5:0] off;
    case (idx)
      4'd0:    off = 6'd20;
      4'd1:    off = 6'd28;
      4'd2:    off = 6'd36;
      4'd3:    off = 6'd40;
      4'd4:    off = 6'd44;
      4'd5:    off = 6'd48;
      default: off = 6'd20;
    endcase
    return off;
  endfunction

endpackage

`default_nettype wire

[sv/charger_status_frame_parser_top.sv]
// a frame-closing byte or timeout tick starts a job; its results pass the memory read
// and output registers, one per cycle from the single read port unless output stalls
// throughput: one request per cycle; a request that would start a new result burst
// waits while the previous burst is still being read out of the frame memory
// reset: synchronous active-low rst_n clears framing, counters and output valid and
// reloads the default timeout; the frame memory is not cleared
// ---------------------------------------------------------------------------
// charger_status_frame_parser_top
// frames serial bytes, checks code, checksum and length, decodes status and log
// fields from a two-bank word memory, while out_tready holds, one result per cycle
// ---------------------------------------------------------------------------
`default_nettype none

module charger_status_frame_parser_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // rx_byte
  input  wire logic [0:0]  in_tuser,   // op
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [39:0]      out_tdata,  // field_index[3:0], field_value[35:4], zero fill
  output logic [2:0]       out_tuser,  // frame_status
  output logic             out_tlast,  // last
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [15:0] cfg_data    // timeout_ticks
);
  import csfp_pkg::*;

  // framing state
  logic        in_frame_r, in_frame_nxt;
  logic [8:0]  byte_cnt_r, byte_cnt_nxt;
  logic [7:0]  pay_cnt_r, pay_cnt_nxt;
  logic [7:0]  sum_r, sum_nxt;
  logic [15:0] idle_cnt_r, idle_cnt_nxt;
  logic [7:0]  code_r, code_nxt;
  logic [7:0]  item_r, item_nxt;
  logic        bank_r, bank_nxt;
  logic [15:0] timeout_r;

  // result job
  logic        job_act_r, job_act_nxt;
  job_kind_t   job_kind_r, job_kind_nxt;
  fstat_t      job_stat_r, job_stat_nxt;
  logic        job_bank_r, job_bank_nxt;
  logic [3:0]  job_idx_r, job_idx_nxt;

  // read in flight
  logic        pend_r, pend_nxt;
  fstat_t      pend_stat_r, pend_stat_nxt;
  logic [3:0]  pend_idx_r, pend_idx_nxt;
  logic        pend_last_r, pend_last_nxt;
  logic        pend_half_r, pend_half_nxt;
  job_kind_t   pend_kind_r, pend_kind_nxt;

  // output register
  logic        out_valid_r, out_valid_nxt;
  logic [39:0] out_data_r, out_data_nxt;
  logic [2:0]  out_user_r, out_user_nxt;
  logic        out_last_r, out_last_nxt;

  // frame memory
  logic [31:0] mem_r [MEM_DEPTH];
  logic [31:0] rdata_r;

  logic        acc, op, start_byte, close, tmo, would_emit;
  logic [7:0]  c, sum_new, pay_new, code_new, item_new;
  logic [8:0]  cnt_base, cnt_inc;
  logic [7:0]  sum_base;
  logic [15:0] idle_inc;
  logic        wr_en;
  logic [MEM_AW-1:0] wr_addr, rd_addr;
  logic [1:0]  wr_lane;
  logic        issue, load;
  logic [3:0]  job_last;
  logic [5:0]  rd_off;
  logic [31:0] value;

  assign acc = in_tvalid && in_tready;
  assign op  = in_tuser[0];
  assign c   = in_tdata;

  assign cnt_base   = in_frame_r ? byte_cnt_r : 9'd0;
  assign sum_base   = in_frame_r ? sum_r : 8'd0;
  assign cnt_inc    = (cnt_base == CNT_MAX) ? cnt_base : cnt_base + 9'd1;
  assign sum_new    = sum_base + c;
  assign pay_new    = (cnt_inc == PAY_POS) ? c : pay_cnt_r;
  assign code_new   = (cnt_base == CODE_POS) ? c : code_r;
  assign item_new   = (cnt_base == ITEM_POS) ? c : item_r;
  assign start_byte = !op && (in_frame_r || c == SYNC_BYTE);
  assign close      = start_byte && cnt_inc > PAY_POS && cnt_inc == {1'b0, pay_new} + HDR_LEN;
  assign idle_inc   = (idle_cnt_r == IDLE_MAX) ? idle_cnt_r : idle_cnt_r + 16'd1;
  assign tmo        = op && in_frame_r && idle_inc >= timeout_r;
  assign would_emit = op ? tmo : close;

  assign in_tready = !job_act_r || !would_emit;
  assign cfg_ready = 1'b1;

  assign wr_en   = acc && start_byte && cnt_base < STORE_DEPTH;
  assign wr_addr = {bank_r, cnt_base[5:2]};
  assign wr_lane = cnt_base[1:0];

  assign job_last = (job_kind_r == JOB_STAT) ? STAT_LAST :
                    (job_kind_r == JOB_LOG)  ? LOG_LAST  : 4'd0;
  assign rd_off   = (job_kind_r == JOB_LOG) ? log_off(job_idx_r) : stat_off(job_idx_r);
  assign rd_addr  = {job_bank_r, rd_off[5:2]};
  assign load     = pend_r && (!out_valid_r || out_tready);
  assign issue    = job_act_r && (!pend_r || load);

  always_comb begin
    case (pend_kind_r)
      JOB_STAT: value = {16'd0, pend_half_r ? rdata_r[31:16] : rdata_r[15:0]};
      JOB_LOG:  value = rdata_r;
      default:  value = 32'd0;
    endcase
  end

  // framing and job start
  always_comb begin
    in_frame_nxt = in_frame_r;
    byte_cnt_nxt = byte_cnt_r;
    pay_cnt_nxt  = pay_cnt_r;
    sum_nxt      = sum_r;
    idle_cnt_nxt = idle_cnt_r;
    code_nxt     = code_r;
    item_nxt     = item_r;
    bank_nxt     = bank_r;
    job_act_nxt  = job_act_r;
    job_kind_nxt = job_kind_r;
    job_stat_nxt = job_stat_r;
    job_bank_nxt = job_bank_r;
    job_idx_nxt  = job_idx_r;

    if (issue) begin
      job_idx_nxt = job_idx_r + 4'd1;
      if (job_idx_r == job_last) begin
        job_act_nxt = 1'b0;
      end
    end

    if (acc) begin
      if (op) begin
        if (in_frame_r) begin
          idle_cnt_nxt = idle_inc;
          if (tmo) begin
            in_frame_nxt = 1'b0;
            byte_cnt_nxt = 9'd0;
            sum_nxt      = 8'd0;
            idle_cnt_nxt = 16'd0;
            job_act_nxt  = 1'b1;
            job_kind_nxt = JOB_ERR;
            job_stat_nxt = FS_TIMEOUT;
            job_idx_nxt  = 4'd0;
          end
        end
      end else begin
        idle_cnt_nxt = 16'd0;
        if (start_byte) begin
          in_frame_nxt = 1'b1;
          byte_cnt_nxt = cnt_inc;
          sum_nxt      = sum_new;
          pay_cnt_nxt  = pay_new;
          code_nxt     = code_new;
          item_nxt     = item_new;
          if (close) begin
            in_frame_nxt = 1'b0;
            byte_cnt_nxt = 9'd0;
            sum_nxt      = 8'd0;
            bank_nxt     = !bank_r;
            job_act_nxt  = 1'b1;
            job_bank_nxt = bank_r;
            job_idx_nxt  = 4'd0;
            job_kind_nxt = JOB_ERR;
            job_stat_nxt = FS_UNKNOWN;
            if (code_new != RESP_CODE) begin
              job_stat_nxt = FS_BAD_CODE;
            end else if (sum_new != 8'd0) begin
              job_stat_nxt = FS_CHECKSUM;
            end else if (item_new == ITEM_STATUS) begin
              if (cnt_inc < STATUS_MIN_LEN) begin
                job_stat_nxt = FS_SHORT;
              end else begin
                job_kind_nxt = JOB_STAT;
              end
            end else if (item_new == ITEM_LOG) begin
              if (cnt_inc < LOG_MIN_LEN) begin
                job_stat_nxt = FS_SHORT;
              end else begin
                job_kind_nxt = JOB_LOG;
              end
            end
          end
        end
      end
    end
  end

  // read in flight and output register
  always_comb begin
    pend_nxt      = pend_r;
    pend_stat_nxt = pend_stat_r;
    pend_idx_nxt  = pend_idx_r;
    pend_last_nxt = pend_last_r;
    pend_half_nxt = pend_half_r;
    pend_kind_nxt = pend_kind_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    out_user_nxt  = out_user_r;
    out_last_nxt  = out_last_r;

    if (issue) begin
      pend_nxt      = 1'b1;
      pend_kind_nxt = job_kind_r;
      pend_half_nxt = rd_off[1];
      pend_last_nxt = (job_idx_r == job_last);
      case (job_kind_r)
        JOB_STAT: begin
          pend_stat_nxt = FS_STAT_FIELD;
          pend_idx_nxt  = job_idx_r;
        end
        JOB_LOG: begin
          pend_stat_nxt = FS_LOG_FIELD;
          pend_idx_nxt  = job_idx_r;
        end
        default: begin
          pend_stat_nxt = job_stat_r;
          pend_idx_nxt  = 4'd0;
        end
      endcase
    end else if (load) begin
      pend_nxt = 1'b0;
    end

    if (load) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = {4'd0, value, pend_idx_r};
      out_user_nxt  = pend_stat_r;
      out_last_nxt  = pend_last_r;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r  <= 1'b0;
      byte_cnt_r  <= 9'd0;
      pay_cnt_r   <= 8'd0;
      sum_r       <= 8'd0;
      idle_cnt_r  <= 16'd0;
      bank_r      <= 1'b0;
      timeout_r   <= TIMEOUT_RST;
      job_act_r   <= 1'b0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_frame_r  <= in_frame_nxt;
      byte_cnt_r  <= byte_cnt_nxt;
      pay_cnt_r   <= pay_cnt_nxt;
      sum_r       <= sum_nxt;
      idle_cnt_r  <= idle_cnt_nxt;
      bank_r      <= bank_nxt;
      job_act_r   <= job_act_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid) begin
        timeout_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    code_r      <= code_nxt;
    item_r      <= item_nxt;
    job_kind_r  <= job_kind_nxt;
    job_stat_r  <= job_stat_nxt;
    job_bank_r  <= job_bank_nxt;
    job_idx_r   <= job_idx_nxt;
    pend_stat_r <= pend_stat_nxt;
    pend_idx_r  <= pend_idx_nxt;
    pend_last_r <= pend_last_nxt;
    pend_half_r <= pend_half_nxt;
    pend_kind_r <= pend_kind_nxt;
    out_data_r  <= out_data_nxt;
    out_user_r  <= out_user_nxt;
    out_last_r  <= out_last_nxt;
  end

  // frame memory, byte-lane write, registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr][{wr_lane, 3'b000} +: 8] <= c;
    end
    if (issue) begin
      rdata_r <= mem_r[rd_addr];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;
  assign out_tlast  = out_last_r;

endmodule

`default_nettype wire

[sv/csfp_checker.sv]
// ---------------------------------------------------------------------------
// csfp_checker
// port-level checks of the charger status frame parser result stream
// ---------------------------------------------------------------------------
`default_nettype none

module csfp_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic [7:0]  in_tdata,
  input wire logic [0:0]  in_tuser,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [39:0] out_tdata,
  input wire logic [2:0]  out_tuser,
  input wire logic        out_tlast,
  input wire logic        cfg_valid,
  input wire logic        cfg_ready,
  input wire logic [15:0] cfg_data
);
  import csfp_pkg::*;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // error results are single, with zero index and value
  a_err_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser >= FS_BAD_CODE |-> out_tlast && out_tdata == 40'd0)
    else $error("malformed error result");

  // status fields end at the last status index
  a_stat_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == FS_STAT_FIELD |-> out_tdata[3:0] <= STAT_LAST &&
      out_tlast == (out_tdata[3:0] == STAT_LAST) && out_tdata[39:20] == 20'd0)
    else $error("bad status field result");

  // log fields end at the last log index
  a_log_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == FS_LOG_FIELD |-> out_tdata[3:0] <= LOG_LAST &&
      out_tlast == (out_tdata[3:0] == LOG_LAST))
    else $error("bad log field result");

  // nothing shown right after reset
  a_rst_quiet: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind charger_status_frame_parser_top csfp_checker u_csfp_checker (.*);

`default_nettype wire
